// ===== sv/assert_macros.svh =====
// Assertion macros for the positional list block.
// Depends on nothing; the including module supplies clk and rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Checked at every rising edge outside reset.
`define PLID_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Checked only on the edge after a qualifying cycle.
`define PLID_ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) else $error(msg);
`else
`define PLID_ASSERT(label, prop, msg)
`define PLID_ASSERT_NEXT(label, cond, prop, msg)
`endif
`endif

// ===== sv/plid_pkg.sv =====
// Types and constants for the positional list block.
// Depends on nothing; used by positional_list_insert_delete.
package plid_pkg;

  localparam int CAPACITY = 32;
  localparam int ELEM_W   = 32;
  localparam int VALUE_W  = 32;
  localparam int POS_W    = 6;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int IDX_W    = $clog2(CAPACITY);
  // Wide enough for position, count + 1 and every cell index.
  localparam int CMP_W    = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

  localparam logic [1:0] MODE_INSERT = 2'd0;
  localparam logic [1:0] MODE_DELETE = 2'd1;
  localparam logic [1:0] MODE_READ   = 2'd2;

  typedef struct packed {
    logic [1:0]                mode;
    logic [POS_W-1:0]          position;
    logic signed [VALUE_W-1:0] value;
  } plid_in_t;

  typedef struct packed {
    logic                      ok;
    logic signed [VALUE_W-1:0] read_value;
    logic [CNT_W-1:0]          length;
  } plid_out_t;

endpackage

// ===== sv/positional_list_insert_delete.sv =====
// Channel   | Handshake              | Payload
// ----------+------------------------+---------------------------------
// in        | in_valid / in_ready    | in_data  (mode, position, value)
// out       | out_valid / out_ready  | out_data (ok, read_value, length)
//
// One transfer is taken per cycle unless the output stalls; the input register loads at the
// input transfer and the result register loads from it once the result register is free.
// The list is a row of cells that all shift in the same cycle, so the whole
// insert or delete is one pass of compare-and-select per cell.
// rst_n (synchronous) empties the list; cell contents are not cleared.
// A stall at the output holds the result register and then the input register.
// Depends on plid_pkg and assert_macros.svh.
`include "assert_macros.svh"

module positional_list_insert_delete (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  plid_pkg::plid_in_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output plid_pkg::plid_out_t out_data
);

  logic                                  s1_valid_r;
  plid_pkg::plid_in_t                    s1_r;
  logic                                  out_valid_r;
  plid_pkg::plid_out_t                   out_r;
  logic [plid_pkg::CNT_W-1:0]            count_r;
  logic [plid_pkg::CNT_W-1:0]            count_nxt;
  logic signed [plid_pkg::ELEM_W-1:0]    cells_r   [plid_pkg::CAPACITY];
  logic signed [plid_pkg::ELEM_W-1:0]    cells_nxt [plid_pkg::CAPACITY];

  logic                                  advance;
  logic [plid_pkg::CMP_W-1:0]            pos_w;
  logic [plid_pkg::CMP_W-1:0]            cnt_w;
  logic [plid_pkg::CMP_W-1:0]            idx_w;
  logic                                  ins_ok;
  logic                                  del_ok;
  logic                                  rd_ok;
  plid_pkg::plid_out_t                   res;

  // The result register frees as it is read, so the input register moves on.
  assign advance  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || advance;

  assign pos_w = plid_pkg::CMP_W'(s1_r.position);
  assign cnt_w = plid_pkg::CMP_W'(count_r);
  assign idx_w = pos_w - plid_pkg::CMP_W'(1);

  assign ins_ok = (s1_r.mode == plid_pkg::MODE_INSERT) && (pos_w != '0)
               && (pos_w <= cnt_w + plid_pkg::CMP_W'(1))
               && (cnt_w < plid_pkg::CMP_W'(plid_pkg::CAPACITY));
  assign del_ok = (s1_r.mode == plid_pkg::MODE_DELETE) && (pos_w != '0)
               && (pos_w <= cnt_w);
  assign rd_ok  = (s1_r.mode == plid_pkg::MODE_READ) && (pos_w != '0)
               && (pos_w <= cnt_w);

  always_comb begin
    count_nxt = count_r;
    if (ins_ok) begin
      count_nxt = count_r + plid_pkg::CNT_W'(1);
    end else if (del_ok) begin
      count_nxt = count_r - plid_pkg::CNT_W'(1);
    end
  end

  always_comb begin
    res.ok         = ins_ok || del_ok || rd_ok;
    res.read_value = '0;
    if (rd_ok) begin
      res.read_value = plid_pkg::VALUE_W'(cells_r[idx_w[plid_pkg::IDX_W-1:0]]);
    end
    res.length = count_nxt;
  end

  // Each cell picks its neighbour below, the new value, its neighbour above
  // or itself, from a compare of its own index with the target index.
  for (genvar g = 0; g < plid_pkg::CAPACITY; g++) begin : g_cell
    localparam logic [plid_pkg::CMP_W-1:0] CellIdx = plid_pkg::CMP_W'(g);
    always_comb begin
      cells_nxt[g] = cells_r[g];
      if (ins_ok) begin
        if (CellIdx == idx_w) begin
          cells_nxt[g] = plid_pkg::ELEM_W'(s1_r.value);
        end else if (CellIdx > idx_w) begin
          cells_nxt[g] = cells_r[(g == 0) ? 0 : g - 1];
        end
      end else if (del_ok) begin
        if (CellIdx >= idx_w && g < plid_pkg::CAPACITY - 1) begin
          cells_nxt[g] = cells_r[(g == plid_pkg::CAPACITY - 1) ? g : g + 1];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (advance) begin
        cells_r[g] <= cells_nxt[g];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      count_r     <= '0;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
        count_r     <= count_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_r <= in_data;
    end
    if (advance) begin
      out_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `PLID_ASSERT(a_count_in_range, count_r <= plid_pkg::CNT_W'(plid_pkg::CAPACITY), "count above capacity")
  `PLID_ASSERT_NEXT(a_count_held, !advance, $stable(count_r), "count changed without a transfer")
  `PLID_ASSERT_NEXT(a_insert_grows, advance && ins_ok, count_r == $past(count_r) + plid_pkg::CNT_W'(1), "insert did not grow the list")
  `PLID_ASSERT(a_reject_zero, !(out_valid_r && !out_r.ok) || (out_r.read_value == '0), "rejected result carries data")

endmodule

// ===== tb/tb_positional_list_insert_delete.sv =====
// Self-checking testbench for positional_list_insert_delete: insert, delete and read
// commands against a list mirror kept in the bench, with random idling on both channels.
// Depends on plid_pkg and the block itself.
module tb_positional_list_insert_delete;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int RX_HOLD_CYCLES = 400;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int TAIL_CYCLES    = 8;

  // Mirror of the list contents; it predicts one result per accepted command.
  class list_mirror;
    logic signed [plid_pkg::VALUE_W-1:0] cells[plid_pkg::CAPACITY];
    int                                  held;
    plid_pkg::plid_out_t                 pending_results[$];
    int                                  mismatches;

    function new();
      held = 0;
      mismatches = 0;
    endfunction

    function void apply_command(plid_pkg::plid_in_t cmd);
      plid_pkg::plid_out_t res;
      int                  pos;
      int                  i;
      res = '0;
      pos = int'(cmd.position);
      case (cmd.mode)
        plid_pkg::MODE_INSERT: begin
          if (pos >= 1 && pos <= held + 1 && held < plid_pkg::CAPACITY) begin
            for (i = held; i >= pos; i--) cells[i] = cells[i-1];
            cells[pos-1] = cmd.value;
            held++;
            res.ok = 1'b1;
          end
        end
        plid_pkg::MODE_DELETE: begin
          if (pos >= 1 && pos <= held) begin
            for (i = pos; i < held; i++) cells[i-1] = cells[i];
            held--;
            res.ok = 1'b1;
          end
        end
        plid_pkg::MODE_READ: begin
          if (pos >= 1 && pos <= held) begin
            res.read_value = cells[pos-1];
            res.ok = 1'b1;
          end
        end
        default: ;
      endcase
      res.length = plid_pkg::CNT_W'(held);
      pending_results.push_back(res);
    endfunction

    function void compare_result(plid_pkg::plid_out_t got);
      plid_pkg::plid_out_t want;
      if (pending_results.size() == 0) begin
        $error("result with nothing outstanding: ok %0d read_value %0d length %0d",
               got.ok, got.read_value, got.length);
        mismatches++;
        return;
      end
      want = pending_results.pop_front();
      if (got.ok !== want.ok) begin
        $error("ok: expected %0d, got %0d", want.ok, got.ok);
        mismatches++;
      end
      if (got.read_value !== want.read_value) begin
        $error("read_value: expected %0d, got %0d", want.read_value, got.read_value);
        mismatches++;
      end
      if (got.length !== want.length) begin
        $error("length: expected %0d, got %0d", want.length, got.length);
        mismatches++;
      end
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  plid_pkg::plid_in_t  in_data;
  logic                out_valid;
  logic                out_ready;
  plid_pkg::plid_out_t out_data;

  list_mirror mirror;
  int         send_idle_pct = 0;
  int         recv_idle_pct = 0;
  int         hold_requests = 0;
  int         holds_served = 0;
  bit         growing = 1'b1;

  positional_list_insert_delete uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #2 clk = ~clk;

  function automatic plid_pkg::plid_in_t command(logic [1:0] mode, int pos,
                                                 logic [31:0] value);
    plid_pkg::plid_in_t cmd;
    cmd.mode = mode;
    cmd.position = plid_pkg::POS_W'(pos);
    cmd.value = value;
    return cmd;
  endfunction

  // Mostly in-range positions so that the list fills and empties; the rest is noise.
  function automatic plid_pkg::plid_in_t random_command(int held, bit grow);
    plid_pkg::plid_in_t cmd;
    int                 r;
    int                 top;
    r = $urandom_range(99);
    if (r < 5) cmd.mode = MODE_UNUSED;
    else if (r < (grow ? 60 : 25)) cmd.mode = plid_pkg::MODE_INSERT;
    else if (r < 75) cmd.mode = plid_pkg::MODE_DELETE;
    else cmd.mode = plid_pkg::MODE_READ;
    top = (cmd.mode == plid_pkg::MODE_INSERT) ? held + 1 : ((held > 0) ? held : 1);
    r = $urandom_range(99);
    if (r < 8) cmd.position = '0;
    else if (r < 16) cmd.position = plid_pkg::POS_W'($urandom_range(63));
    else cmd.position = plid_pkg::POS_W'($urandom_range(top, 1));
    r = $urandom_range(99);
    if (r < 5) cmd.value = 32'h7fff_ffff;
    else if (r < 10) cmd.value = 32'h8000_0000;
    else if (r < 13) cmd.value = '0;
    else if (r < 16) cmd.value = '1;
    else cmd.value = $urandom;
    return cmd;
  endfunction

  task automatic send_item(input plid_pkg::plid_in_t cmd);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_data <= cmd;
    do @(posedge clk); while (!in_ready);
    mirror.apply_command(cmd);
  endtask

  // Stop offering and wait until every predicted result has been checked.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (mirror.pending_results.size() != 0);
  endtask

  task automatic run_random(int n);
    repeat (n) begin
      if (mirror.held == plid_pkg::CAPACITY) growing = 1'b0;
      else if (mirror.held == 0) growing = 1'b1;
      send_item(random_command(mirror.held, growing));
    end
  endtask

  initial begin : result_sink
    int hold_left;
    hold_left = 0;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) mirror.compare_result(out_data);
      if (holds_served != hold_requests) begin
        holds_served = hold_requests;
        hold_left = RX_HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= (recv_idle_pct == 0) || ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
      if (quiet >= WATCHDOG_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin
    mirror = new();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: rejections on an empty list, extremes, front, middle and end inserts.
    send_item(command(plid_pkg::MODE_READ, 1, 0));
    send_item(command(plid_pkg::MODE_DELETE, 1, 0));
    send_item(command(plid_pkg::MODE_INSERT, 0, 32'h1234_5678));
    send_item(command(plid_pkg::MODE_INSERT, 2, 32'h1234_5678));
    send_item(command(plid_pkg::MODE_INSERT, 1, 32'h7fff_ffff));
    send_item(command(plid_pkg::MODE_INSERT, 1, 32'h8000_0000));
    send_item(command(plid_pkg::MODE_INSERT, 3, 32'hffff_ffff));
    send_item(command(plid_pkg::MODE_INSERT, 2, 32'h0000_0000));
    send_item(command(plid_pkg::MODE_INSERT, 63, 32'h0f0f_0f0f));
    send_item(command(plid_pkg::MODE_READ, 0, 0));
    send_item(command(plid_pkg::MODE_READ, 1, 0));
    send_item(command(plid_pkg::MODE_READ, 2, 0));
    send_item(command(plid_pkg::MODE_READ, 3, 0));
    send_item(command(plid_pkg::MODE_READ, 4, 0));
    send_item(command(plid_pkg::MODE_READ, 5, 0));
    send_item(command(MODE_UNUSED, 1, 32'hdead_beef));
    send_item(command(plid_pkg::MODE_DELETE, 0, 0));
    send_item(command(plid_pkg::MODE_DELETE, 5, 0));
    send_item(command(plid_pkg::MODE_DELETE, 2, 0));
    send_item(command(plid_pkg::MODE_READ, 2, 0));
    send_item(command(plid_pkg::MODE_DELETE, 3, 0));
    send_item(command(plid_pkg::MODE_DELETE, 1, 0));
    send_item(command(plid_pkg::MODE_READ, 1, 0));
    send_item(command(plid_pkg::MODE_DELETE, 1, 0));
    send_item(command(plid_pkg::MODE_INSERT, 1, 32'h5555_aaaa));

    send_idle_pct = 23;
    recv_idle_pct = 68;
    run_random(510);
    drain();

    send_idle_pct = 68;
    recv_idle_pct = 23;
    run_random(510);
    drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(250);
    // The receiver stalls for a long stretch while commands keep coming.
    hold_requests++;
    run_random(40);
    run_random(250);

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mirror.mismatches == 0 && mirror.pending_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
